// ----- rtl/core/ucordic_pkg.sv -----
// ----------------------------------------------------------------------------
// ucordic_pkg
// Shared types, codes, defaults and micro-rotation angle tables for the
// unified CORDIC engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ucordic_pkg;

	// default configuration of the engine
	localparam int DEF_STEP_COUNT       = 16;
	localparam int DEF_HYPER_STEP_COUNT = 15;
	localparam int DEF_DATA_WIDTH       = 18;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_COORD_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OP_KIND    = 1'd1;

	// coordinate system codes
	localparam logic [1:0] MODE_LIN  = 2'd0;
	localparam logic [1:0] MODE_CIRC = 2'd1;
	localparam logic [1:0] MODE_HYP  = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	// operation codes
	localparam logic OP_VEC = 1'b0;
	localparam logic OP_ROT = 1'b1;

	// angles are unsigned, 14 fraction bits, below 2.0
	localparam int ANG_W = 15;

	localparam logic [ANG_W-1:0] CIRC_TAB [0:15] = '{
		15'd12868, 15'd7596, 15'd4014, 15'd2037, 15'd1023, 15'd512, 15'd256, 15'd128,
		15'd64,    15'd32,   15'd16,   15'd8,    15'd4,    15'd2,   15'd1,   15'd0
	};

	localparam logic [ANG_W-1:0] HYP_TAB [0:15] = '{
		15'd0,  15'd9000, 15'd4185, 15'd2059, 15'd1025, 15'd512, 15'd256, 15'd128,
		15'd64, 15'd32,   15'd16,   15'd8,    15'd4,    15'd2,   15'd1,   15'd1
	};

	// control that travels with each item down the pipeline
	typedef struct packed {
		logic       valid;
		logic [1:0] mode;
		logic       op;
	} ctl_t;

	// atan(2^-i)
	function automatic logic [ANG_W-1:0] circ_angle(input int unsigned idx);
		logic [ANG_W-1:0] a;
		a = '0;
		if (idx < 16) begin
			a = CIRC_TAB[idx[3:0]];
		end
		return a;
	endfunction

	// atanh(2^-i)
	function automatic logic [ANG_W-1:0] hyp_angle(input int unsigned idx);
		logic [ANG_W-1:0] a;
		a = '0;
		if (idx < 16) begin
			a = HYP_TAB[idx[3:0]];
		end
		return a;
	endfunction

	// 2^-i
	function automatic logic [ANG_W-1:0] lin_angle(input int unsigned idx);
		logic [ANG_W-1:0] a;
		a = '0;
		if (idx < 15) begin
			a = ANG_W'(32'd16384 >> idx);
		end
		return a;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ucordic_step.sv -----
// ----------------------------------------------------------------------------
// ucordic_step
// One registered micro-rotation stage with a fixed shift. Whether the stage
// acts depends on the item's coordinate mode and the stage's position.
// ----------------------------------------------------------------------------
`default_nettype none

module ucordic_step #(
	parameter int STEP_IDX         = 0,
	parameter int STEP_COUNT       = 16,
	parameter int HYPER_STEP_COUNT = 15,
	parameter int IW               = 22
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire ucordic_pkg::ctl_t     up_ctl,
	input  wire logic signed [IW-1:0]  up_x,
	input  wire logic signed [IW-1:0]  up_y,
	input  wire logic signed [IW-1:0]  up_z,
	output ucordic_pkg::ctl_t          ctl_s1,
	output logic signed [IW-1:0]       x_s1,
	output logic signed [IW-1:0]       y_s1,
	output logic signed [IW-1:0]       z_s1
);
	import ucordic_pkg::*;

	localparam bit RUN_LC  = (STEP_IDX < STEP_COUNT);
	localparam bit RUN_HYP = (STEP_IDX >= 1) && (STEP_IDX <= HYPER_STEP_COUNT);

	localparam logic [ANG_W-1:0] ANG_LIN  = lin_angle(STEP_IDX);
	localparam logic [ANG_W-1:0] ANG_CIRC = circ_angle(STEP_IDX);
	localparam logic [ANG_W-1:0] ANG_HYP  = hyp_angle(STEP_IDX);

	logic                   active;
	logic [ANG_W-1:0]       ang;
	logic signed [IW-1:0]   ang_w;
	logic signed [IW-1:0]   test;
	logic                   neg;
	logic                   go;
	logic signed [IW-1:0]   xs;
	logic signed [IW-1:0]   ys;
	logic signed [IW-1:0]   x_n;
	logic signed [IW-1:0]   y_n;
	logic signed [IW-1:0]   z_n;

	always_comb begin
		active = 1'b0;
		ang    = '0;
		unique case (up_ctl.mode)
			MODE_LIN: begin
				active = RUN_LC;
				ang    = ANG_LIN;
			end
			MODE_CIRC: begin
				active = RUN_LC;
				ang    = ANG_CIRC;
			end
			MODE_HYP: begin
				active = RUN_HYP;
				ang    = ANG_HYP;
			end
			MODE_NONE: begin
				active = 1'b0;
			end
		endcase
	end

	assign ang_w = IW'($signed({1'b0, ang}));
	assign xs    = up_x >>> STEP_IDX;
	assign ys    = up_y >>> STEP_IDX;

	// d = -1 when y > 0 (vectoring) or z < 0 (rotation); zero test value holds
	assign test = (up_ctl.op == OP_VEC) ? up_y : up_z;
	assign neg  = (up_ctl.op == OP_VEC) ? !test[IW-1] : test[IW-1];
	assign go   = active && (test != '0);

	always_comb begin
		x_n = up_x;
		y_n = up_y;
		z_n = up_z;
		if (go) begin
			y_n = neg ? (up_y - xs) : (up_y + xs);
			z_n = neg ? (up_z + ang_w) : (up_z - ang_w);
			if (up_ctl.mode == MODE_CIRC) begin
				x_n = neg ? (up_x + ys) : (up_x - ys);
			end else if (up_ctl.mode == MODE_HYP) begin
				x_n = neg ? (up_x - ys) : (up_x + ys);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= up_ctl;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x_n;
		y_s1 <= y_n;
		z_s1 <= z_n;
	end

endmodule

`default_nettype wire

// ----- rtl/core/ucordic_sat.sv -----
// ----------------------------------------------------------------------------
// ucordic_sat
// Output stage: saturates the wide x, y, z to the result width, raises the
// overflow flag and registers the result with its strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module ucordic_sat #(
	parameter int DATA_WIDTH = 18,
	parameter int IW         = 22
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire ucordic_pkg::ctl_t            up_ctl,
	input  wire logic signed [IW-1:0]         up_x,
	input  wire logic signed [IW-1:0]         up_y,
	input  wire logic signed [IW-1:0]         up_z,
	output logic                              done_s1,
	output logic signed [DATA_WIDTH-1:0]      x_s1,
	output logic signed [DATA_WIDTH-1:0]      y_s1,
	output logic signed [DATA_WIDTH-1:0]      z_s1,
	output logic                              ovf_s1
);
	import ucordic_pkg::*;

	localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// value fits when all bits from the result sign bit upward agree
	function automatic logic fits(input logic signed [IW-1:0] v);
		logic [IW-DATA_WIDTH:0] hi;
		hi = v[IW-1:DATA_WIDTH-1];
		return (&hi) || (~|hi);
	endfunction

	function automatic logic [DATA_WIDTH-1:0] clip(input logic signed [IW-1:0] v);
		logic [DATA_WIDTH-1:0] r;
		if (fits(v)) begin
			r = v[DATA_WIDTH-1:0];
		end else begin
			r = v[IW-1] ? SMIN : SMAX;
		end
		return r;
	endfunction

	logic ovf_n;

	assign ovf_n = !fits(up_x) || !fits(up_y) || !fits(up_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= up_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s1   <= clip(up_x);
		y_s1   <= clip(up_y);
		z_s1   <= clip(up_z);
		ovf_s1 <= ovf_n;
	end

endmodule

`default_nettype wire

// ----- rtl/core/unified_cordic_engine.sv -----
// ----------------------------------------------------------------------------
// unified_cordic_engine
// Unrolled CORDIC pipeline for linear, circular and hyperbolic coordinates,
// in rotation or vectoring, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
//  channel   ports                              direction  timing
//  command   start, busy, x_in, y_in, z_in     in         taken when start & !busy
//  result    done, x_out, y_out, z_out,        out        one-cycle strobe on done
//            overflow_flag
//  config    cfg_wr_en, cfg_index, cfg_data    in         written when cfg_wr_en
//
//  One item per cycle; each item passes through all registers of the path
//  (input register, one stage per micro-rotation, saturation register).
//  busy is always low: the pipeline never stalls and the result side cannot
//  push back. Each item carries its mode and operation down the pipeline.
//  arst_n clears the valid bits and sets circular mode, rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module unified_cordic_engine #(
	parameter int STEP_COUNT       = ucordic_pkg::DEF_STEP_COUNT,
	parameter int HYPER_STEP_COUNT = ucordic_pkg::DEF_HYPER_STEP_COUNT,
	parameter int DATA_WIDTH       = ucordic_pkg::DEF_DATA_WIDTH
) (
	input  wire                                        clk,
	input  wire                                        arst_n,
	input  wire                                        start,
	output logic                                       busy,
	input  wire logic signed [DATA_WIDTH-1:0]          x_in,
	input  wire logic signed [DATA_WIDTH-1:0]          y_in,
	input  wire logic signed [DATA_WIDTH-1:0]          z_in,
	input  wire                                        cfg_wr_en,
	input  wire logic [ucordic_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ucordic_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                       done,
	output logic signed [DATA_WIDTH-1:0]               x_out,
	output logic signed [DATA_WIDTH-1:0]               y_out,
	output logic signed [DATA_WIDTH-1:0]               z_out,
	output logic                                       overflow_flag
);
	import ucordic_pkg::*;

	localparam int NSTG = (STEP_COUNT > HYPER_STEP_COUNT + 1) ?
	                      STEP_COUNT : HYPER_STEP_COUNT + 1;
	localparam int LAT  = NSTG + 2;
	// headroom for gain growth and accumulated angles
	localparam int IW   = (DATA_WIDTH + 4 > 20) ? DATA_WIDTH + 4 : 20;

	logic [1:0] coord_mode_q;
	logic       op_kind_q;

	ctl_t                 ctl_pipe [0:NSTG];
	logic signed [IW-1:0] x_pipe   [0:NSTG];
	logic signed [IW-1:0] y_pipe   [0:NSTG];
	logic signed [IW-1:0] z_pipe   [0:NSTG];

	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_mode_q <= MODE_CIRC;
			op_kind_q    <= OP_ROT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_COORD_MODE: coord_mode_q <= cfg_data[1:0];
				REG_OP_KIND:    op_kind_q    <= cfg_data[0];
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_pipe[0] <= '0;
		end else begin
			ctl_pipe[0] <= '{valid: accept, mode: coord_mode_q, op: op_kind_q};
		end
	end

	always_ff @(posedge clk) begin
		x_pipe[0] <= IW'(x_in);
		y_pipe[0] <= IW'(y_in);
		z_pipe[0] <= IW'(z_in);
	end

	for (genvar k = 0; k < NSTG; k++) begin : g_step
		ucordic_step #(
			.STEP_IDX         (k),
			.STEP_COUNT       (STEP_COUNT),
			.HYPER_STEP_COUNT (HYPER_STEP_COUNT),
			.IW               (IW)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.up_ctl (ctl_pipe[k]),
			.up_x   (x_pipe[k]),
			.up_y   (y_pipe[k]),
			.up_z   (z_pipe[k]),
			.ctl_s1 (ctl_pipe[k+1]),
			.x_s1   (x_pipe[k+1]),
			.y_s1   (y_pipe[k+1]),
			.z_s1   (z_pipe[k+1])
		);
	end

	ucordic_sat #(
		.DATA_WIDTH (DATA_WIDTH),
		.IW         (IW)
	) u_sat (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_ctl  (ctl_pipe[NSTG]),
		.up_x    (x_pipe[NSTG]),
		.up_y    (y_pipe[NSTG]),
		.up_z    (z_pipe[NSTG]),
		.done_s1 (done),
		.x_s1    (x_out),
		.y_s1    (y_out),
		.z_s1    (z_out),
		.ovf_s1  (overflow_flag)
	);

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("item accepted but no result after pipeline latency");

	a_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result strobe without an accepted item");

	a_ovf_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow_flag) |->
			(x_out == {1'b0, {(DATA_WIDTH-1){1'b1}}} ||
			 x_out == {1'b1, {(DATA_WIDTH-1){1'b0}}} ||
			 y_out == {1'b0, {(DATA_WIDTH-1){1'b1}}} ||
			 y_out == {1'b1, {(DATA_WIDTH-1){1'b0}}} ||
			 z_out == {1'b0, {(DATA_WIDTH-1){1'b1}}} ||
			 z_out == {1'b1, {(DATA_WIDTH-1){1'b0}}}))
		else $error("overflow flagged but no output at a limit");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_unified_cordic_engine.sv -----
// ----------------------------------------------------------------------------
// tb_unified_cordic_engine
// Drives (x, y, z) vectors through the CORDIC engine under every coordinate
// mode and operation, predicts each result with an independent shift-and-add
// model, and compares all result fields in order of acceptance.
// ----------------------------------------------------------------------------

module tb_unified_cordic_engine;

	timeunit 1ns;
	timeprecision 1ps;

	import ucordic_pkg::*;

	localparam int DW         = DEF_DATA_WIDTH;
	localparam int CIRC_STEPS = DEF_STEP_COUNT;
	localparam int HYP_STEPS  = DEF_HYPER_STEP_COUNT;
	localparam int LATENCY    = ((CIRC_STEPS > HYP_STEPS + 1) ? CIRC_STEPS : HYP_STEPS + 1) + 2;
	localparam int IDLE_LIMIT = 1000;
	localparam int ITEM_GOAL  = 1950;

	localparam logic signed [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] WMIN = {1'b1, {(DW-1){1'b0}}};

	typedef enum logic [1:0] {ST_CMD, ST_CFG, ST_DRAIN} stim_kind_t;

	typedef struct {
		stim_kind_t                kind;
		logic signed [DW-1:0]      x;
		logic signed [DW-1:0]      y;
		logic signed [DW-1:0]      z;
		logic [CFG_IDX_W-1:0]      idx;
		logic [CFG_DATA_W-1:0]     data;
	} stim_t;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] z;
		logic                 ovf;
	} cordic_res_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start = 1'b0;
	logic busy;
	logic signed [DW-1:0] x_in = '0;
	logic signed [DW-1:0] y_in = '0;
	logic signed [DW-1:0] z_in = '0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic done;
	logic signed [DW-1:0] x_out;
	logic signed [DW-1:0] y_out;
	logic signed [DW-1:0] z_out;
	logic overflow_flag;

	stim_t       stim_q[$];
	cordic_res_t result_q[$];

	// configuration as the engine should hold it
	logic [1:0] cur_mode = MODE_CIRC;
	logic       cur_op   = OP_ROT;

	logic cmd_taken = 1'b0;
	int   gap_left = 0;
	int   burst_left = 0;
	int   err_cnt = 0;
	int   idle_cycles = 0;
	int   item_cnt = 0;

	int circ_atan [0:15] = '{12868, 7596, 4014, 2037, 1023, 512, 256, 128,
	                         64, 32, 16, 8, 4, 2, 1, 0};
	int hyp_atanh [0:15] = '{0, 9000, 4185, 2059, 1025, 512, 256, 128,
	                         64, 32, 16, 8, 4, 2, 1, 1};

	unified_cordic_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.x_in          (x_in),
		.y_in          (y_in),
		.z_in          (z_in),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.done          (done),
		.x_out         (x_out),
		.y_out         (y_out),
		.z_out         (z_out),
		.overflow_flag (overflow_flag)
	);

	always #5 clk = ~clk;

	// {saturated, value}
	function automatic logic [DW:0] clamp_word(input longint v);
		longint hi_lim;
		longint lo_lim;
		hi_lim = (longint'(1) << (DW - 1)) - 1;
		lo_lim = -(longint'(1) << (DW - 1));
		if (v > hi_lim) return {1'b1, DW'(hi_lim)};
		if (v < lo_lim) return {1'b1, DW'(lo_lim)};
		return {1'b0, DW'(v)};
	endfunction

	function automatic cordic_res_t cordic_predict(input logic signed [DW-1:0] xi,
			input logic signed [DW-1:0] yi, input logic signed [DW-1:0] zi,
			input logic [1:0] mode, input logic op);
		longint x, y, z, xs, ys, ang, m, d;
		int lo_step, hi_step;
		logic [DW:0] cx, cy, cz;
		cordic_res_t r;
		x = xi;
		y = yi;
		z = zi;
		m = 0;
		lo_step = 0;
		hi_step = CIRC_STEPS - 1;
		case (mode)
			MODE_LIN:  m = 0;
			MODE_CIRC: m = 1;
			MODE_HYP: begin
				m = -1;
				lo_step = 1;
				hi_step = HYP_STEPS;
			end
			default: begin
				// unused code: vector passes straight through
				lo_step = 1;
				hi_step = 0;
			end
		endcase
		for (int i = lo_step; i <= hi_step; i++) begin
			case (mode)
				MODE_LIN:  ang = (i < 15) ? (longint'(16384) >> i) : 0;
				MODE_CIRC: ang = (i < 16) ? circ_atan[i] : 0;
				default:   ang = (i < 16) ? hyp_atanh[i] : 0;
			endcase
			d = 0;
			if (op == OP_VEC) begin
				if (y > 0) d = -1;
				else if (y < 0) d = 1;
			end else begin
				if (z > 0) d = 1;
				else if (z < 0) d = -1;
			end
			xs = x >>> i;
			ys = y >>> i;
			x = x - m * d * ys;
			y = y + d * xs;
			z = z - d * ang;
		end
		cx = clamp_word(x);
		cy = clamp_word(y);
		cz = clamp_word(z);
		r.x = cx[DW-1:0];
		r.y = cy[DW-1:0];
		r.z = cz[DW-1:0];
		r.ovf = cx[DW] | cy[DW] | cz[DW];
		return r;
	endfunction

	task automatic report_err(input string what);
		if (err_cnt < 100) $display("ERROR @%0t: %s", $realtime, what);
		err_cnt++;
	endtask

	task automatic push_cmd(input logic signed [DW-1:0] x, input logic signed [DW-1:0] y,
			input logic signed [DW-1:0] z);
		stim_t s;
		s.kind = ST_CMD;
		s.x = x;
		s.y = y;
		s.z = z;
		s.idx = '0;
		s.data = '0;
		stim_q.push_back(s);
		item_cnt++;
	endtask

	task automatic push_ctl(input stim_kind_t kind, input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		stim_t s;
		s.kind = kind;
		s.x = '0;
		s.y = '0;
		s.z = '0;
		s.idx = idx;
		s.data = data;
		stim_q.push_back(s);
	endtask

	function automatic int srange(input int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	function automatic logic signed [DW-1:0] raw_word();
		case ($urandom_range(0, 7))
			0: return WMAX;
			1: return WMIN;
			2: return '0;
			3: return $urandom_range(0, 1) ? DW'(1) : -DW'(1);
			default: return DW'($urandom);
		endcase
	endfunction

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		stim_t s;
		logic go;
		logic wr;
		go = start;
		wr = 1'b0;
		if (arst_n && !(start && !cmd_taken)) begin
			go = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
			end else if (stim_q.size() != 0) begin
				s = stim_q[0];
				case (s.kind)
					ST_CMD: begin
						s = stim_q.pop_front();
						x_in <= s.x;
						y_in <= s.y;
						z_in <= s.z;
						go = 1'b1;
						if (burst_left != 0) begin
							burst_left--;
						end else begin
							case ($urandom_range(0, 99)) inside
								[0:2]:   burst_left = $urandom_range(30, 200);
								[3:59]:  gap_left = 0;
								[60:89]: gap_left = $urandom_range(1, 3);
								[90:97]: gap_left = $urandom_range(4, 10);
								default: gap_left = $urandom_range(20, 60);
							endcase
						end
					end
					ST_CFG: begin
						// registers only change with the pipeline empty
						if (result_q.size() == 0) begin
							s = stim_q.pop_front();
							cfg_index <= s.idx;
							cfg_data <= s.data;
							wr = 1'b1;
						end
					end
					default: begin
						if (result_q.size() == 0) s = stim_q.pop_front();
					end
				endcase
			end
		end
		start <= go;
		cfg_wr_en <= wr;
	end

	// monitor: tracks config, predicts accepted items, checks results
	always @(posedge clk) begin
		cordic_res_t want;
		if (arst_n) begin
			cmd_taken <= start && !busy;
			if (cfg_wr_en) begin
				if (cfg_index == REG_COORD_MODE) cur_mode = cfg_data[1:0];
				else if (cfg_index == REG_OP_KIND) cur_op = cfg_data[0];
			end
			if (start && !busy) begin
				result_q.push_back(cordic_predict(x_in, y_in, z_in, cur_mode, cur_op));
			end
			if (done) begin
				if (result_q.size() == 0) begin
					report_err("result with no item outstanding");
				end else begin
					want = result_q.pop_front();
					if (x_out !== want.x)
						report_err($sformatf("x_out %0d, want %0d", x_out, want.x));
					if (y_out !== want.y)
						report_err($sformatf("y_out %0d, want %0d", y_out, want.y));
					if (z_out !== want.z)
						report_err($sformatf("z_out %0d, want %0d", z_out, want.z));
					if (overflow_flag !== want.ovf)
						report_err($sformatf("overflow_flag %b, want %b",
							overflow_flag, want.ovf));
				end
			end
		end
	end

	// watchdog on cycles with no traffic at all
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_wr_en) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_unified_cordic_engine failed");
			$finish;
		end
	end

	initial begin
		logic [1:0] mode;
		logic op;
		int zlim;
		int xw;
		int phase_len;

		arst_n = 1'b0;

		// reset config: circular rotation
		push_cmd('0, '0, '0);
		push_cmd(WMAX, WMAX, WMAX);
		push_cmd(WMIN, WMIN, WMIN);
		push_cmd(WMAX, WMIN, '0);
		push_cmd(WMIN, WMAX, DW'(1));
		push_cmd(DW'(16384), '0, DW'(12868));
		push_cmd(DW'(9949), '0, -DW'(8192));

		// hyperbolic vectoring; high bit of the op write must be dropped
		push_ctl(ST_CFG, REG_COORD_MODE, CFG_DATA_W'(MODE_HYP));
		push_ctl(ST_CFG, REG_OP_KIND, {1'b1, OP_VEC});
		push_cmd(DW'(20000), DW'(10000), '0);
		push_cmd(WMAX, WMAX, WMIN);
		push_cmd(DW'(16384), '0, DW'(5));

		// linear rotation: multiply
		push_ctl(ST_CFG, REG_COORD_MODE, CFG_DATA_W'(MODE_LIN));
		push_ctl(ST_CFG, REG_OP_KIND, {1'b1, OP_ROT});
		push_cmd(DW'(16384), '0, DW'(8192));
		push_cmd(WMAX, WMAX, WMAX);
		push_cmd(WMIN, WMIN, '0);

		// unused mode code: pass-through
		push_ctl(ST_CFG, REG_COORD_MODE, CFG_DATA_W'(MODE_NONE));
		push_cmd(WMAX, WMIN, DW'(123));
		push_cmd(WMIN, WMAX, -DW'(5));

		// linear vectoring: divide
		push_ctl(ST_CFG, REG_COORD_MODE, CFG_DATA_W'(MODE_LIN));
		push_ctl(ST_CFG, REG_OP_KIND, {1'b0, OP_VEC});
		push_cmd(DW'(16384), DW'(8192), '0);

		while (item_cnt < ITEM_GOAL) begin
			mode = ($urandom_range(0, 19) == 0) ? MODE_NONE : 2'($urandom_range(0, 2));
			op = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 1)) begin
				push_ctl(ST_CFG, REG_COORD_MODE, CFG_DATA_W'(mode));
				push_ctl(ST_CFG, REG_OP_KIND, {1'($urandom_range(0, 1)), op});
			end else begin
				push_ctl(ST_CFG, REG_OP_KIND, {1'($urandom_range(0, 1)), op});
				push_ctl(ST_CFG, REG_COORD_MODE, CFG_DATA_W'(mode));
			end
			// keep z near the convergence range of the mode
			case (mode)
				MODE_CIRC: zlim = 28000;
				MODE_HYP:  zlim = 18000;
				default:   zlim = 32000;
			endcase
			phase_len = $urandom_range(20, 150);
			for (int n = 0; n < phase_len && item_cnt < ITEM_GOAL; n++) begin
				if ($urandom_range(0, 99) < 2) push_ctl(ST_DRAIN, '0, '0);
				if ($urandom_range(0, 9) < 2) begin
					push_cmd(raw_word(), raw_word(), raw_word());
				end else if (op == OP_VEC) begin
					xw = $urandom_range(2000, 65535);
					push_cmd(DW'(xw), DW'(srange(xw)), DW'(srange(16384)));
				end else begin
					push_cmd(DW'(srange(40000)), DW'(srange(40000)), DW'(srange(zlim)));
				end
			end
		end

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || start || result_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		if (result_q.size() != 0) report_err("results missing at end of run");
		if (err_cnt == 0) $display("tb_unified_cordic_engine passed");
		else $display("tb_unified_cordic_engine failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/ucordic_pkg.sv
rtl/core/ucordic_step.sv
rtl/core/ucordic_sat.sv
rtl/core/unified_cordic_engine.sv
bench/tb_unified_cordic_engine.sv
